/* rtl/ecsm_pkg.sv */
// Shared types and constants for the elliptic-curve scalar multiplier.
// No dependencies.
package ecsm_pkg;
  localparam int FieldWidthDefault = 64;
  localparam int ScalarWidth       = 64;
  localparam int CoordWidth        = 64;

  localparam logic CfgCurveA = 1'b0;
  localparam logic CfgPrimeP = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } fop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fcmd_t;
endpackage

/* rtl/ecsm_field_alu.sv */
// Bit-serial modular arithmetic unit: multiply (one bit of b per cycle),
// add and subtract mod p. Depends on ecsm_pkg.
module ecsm_field_alu import ecsm_pkg::*; #(
  parameter int W = FieldWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  fcmd_t        cmd,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] p,
  output logic         done,
  output logic [W-1:0] r
);
  localparam int CW = $clog2(W + 1);

  logic         busy;
  logic [W-1:0] acc;
  logic [W-1:0] mcand;
  logic [W-1:0] mplier;
  logic [CW-1:0] cnt;

  // x + y mod p for x, y < p (wrap-safe)
  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[W] || s[W-1:0] >= m) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [W-1:0] dbl;
  logic [W-1:0] step;
  always_comb begin
    dbl  = madd(acc, acc, p);
    step = mplier[W-1] ? madd(dbl, mcand, p) : dbl;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      unique case (cmd.op)
        OP_ADD: begin
          r    <= madd(a, b, p);
          done <= 1'b1;
        end
        OP_SUB: begin
          r    <= (a >= b) ? a - b : a + (p - b);
          done <= 1'b1;
        end
        default: begin
          busy   <= 1'b1;
          acc    <= '0;
          mcand  <= a;
          mplier <= b;
          cnt    <= CW'(W);
        end
      endcase
    end else if (busy) begin
      acc    <= step;
      mplier <= mplier << 1;
      cnt    <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        r    <= step;
        done <= 1'b1;
      end
    end
  end
endmodule

/* rtl/ecsm_reduce.sv */
// Bit-serial remainder x mod p, one quotient bit per cycle.
// Depends on ecsm_pkg.
module ecsm_reduce import ecsm_pkg::*; #(
  parameter int W  = FieldWidthDefault,
  parameter int XW = CoordWidth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] x,
  input  logic [W-1:0]  p,
  output logic          done,
  output logic [W-1:0]  r
);
  localparam int CW = $clog2(XW + 1);

  logic          busy;
  logic [W-1:0]  rem;
  logic [XW-1:0] sh;
  logic [CW-1:0] cnt;
  logic [W:0]    t;

  always_comb t = {rem, sh[XW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      sh   <= x;
      cnt  <= CW'(XW);
    end else if (busy) begin
      logic [W:0] n;
      n = (t >= {1'b0, p}) ? t - {1'b0, p} : t;
      rem <= n[W-1:0];
      sh  <= sh << 1;
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        r    <= n[W-1:0];
        done <= 1'b1;
      end
    end
  end
endmodule

/* rtl/ec_scalar_multiply.sv */
// Elliptic-curve scalar multiplier, right-to-left double-and-add.
// Depends on ecsm_pkg, ecsm_field_alu, ecsm_reduce.
//
// Usage: write curve_a (index 0) and prime_p (index 1) on the cfg port
// while idle. Offer a word on s_axis: tdata = {scalar, point_y, point_x},
// tuser = point_at_infinity. One result word comes out on m_axis:
// tdata = {result_y, result_x}, tuser = result_at_infinity.
// One item is worked on at a time; s_axis_tready is low while busy.
// The shared bit-serial unit does field multiplies, adds and subtracts;
// an inversion is up to 2W multiplies (Fermat, exponent p-2), and a
// point operation is one inversion plus a few multiplies. A scalar of
// magnitude k needs up to 2*bitlen(k) point operations.
// Input reduction of curve_a, point_x and point_y runs up front.
// Reset clears the sequencer and sets a=0, p=3. When m_axis stalls the
// result is held in the output register; the next item is accepted once
// the result has been taken.
module ec_scalar_multiply import ecsm_pkg::*; #(
  parameter int FIELD_WIDTH = FieldWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [FIELD_WIDTH-1:0]   cfg_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // point_x, point_y, scalar
  input  logic [191:0]             s_axis_tdata,
  // point_at_infinity
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // result_x, result_y
  output logic [127:0]             m_axis_tdata,
  // result_at_infinity
  output logic                     m_axis_tuser
);
  localparam int W = FIELD_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RX, S_RY, S_NEG, S_LOOP, S_ADD_START,
    S_CHK, S_NUM_DBL1, S_NUM_DBL2, S_NUM_DBL3, S_NUM_DBL4, S_DEN_DBL,
    S_NUM_ADD, S_DEN_ADD, S_POW, S_POW_SQ, S_LAM, S_XR1, S_XR2, S_XR3,
    S_YR1, S_YR2, S_YR3, S_WRITE, S_OUT
  } state_t;

  state_t state;

  logic [W-1:0] curve_a, prime_p;
  logic [W-1:0] a_red;
  logic [W-1:0] acc_x, acc_y, addend_x, addend_y;
  logic         acc_inf, addend_inf;
  logic [ScalarWidth-1:0] scalar_left;
  logic [W-1:0] pow_result, pow_base, pow_exp_left;
  logic [CoordWidth-1:0] in_x, in_y;
  logic         neg;
  logic         is_dbl;  // current op is addend doubling
  logic [W-1:0] x1, y1, x2, y2, num, lam, xr, tmp;

  // field unit
  fcmd_t        fcmd;
  logic [W-1:0] fa, fb;
  logic         fdone;
  logic [W-1:0] fr;

  ecsm_field_alu #(.W(W)) u_alu (
    .clk(clk), .rst(rst), .cmd(fcmd), .a(fa), .b(fb), .p(prime_p),
    .done(fdone), .r(fr)
  );

  logic                  rstart;
  logic [CoordWidth-1:0] rx_in;
  logic                  rdone;
  logic [W-1:0]          rr;

  ecsm_reduce #(.W(W), .XW(CoordWidth)) u_red (
    .clk(clk), .rst(rst), .start(rstart), .x(rx_in), .p(prime_p),
    .done(rdone), .r(rr)
  );

  assign s_axis_tready = (state == S_IDLE);

  logic [W-1:0] y_sum;
  always_comb begin
    logic [W:0] s;
    s = {1'b0, y1} + {1'b0, y2};
    if (s[W] || s[W-1:0] >= prime_p) s = s - {1'b0, prime_p};
    y_sum = s[W-1:0];
  end

  logic [127:0] res_word;
  always_comb begin
    res_word = '0;
    if (!acc_inf) begin
      res_word[W-1:0]           = acc_x;
      res_word[CoordWidth +: W] = acc_y;
    end
  end

  always_ff @(posedge clk) begin
    fcmd.start <= 1'b0;
    rstart     <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      curve_a       <= '0;
      prime_p       <= W'(3);
      m_axis_tvalid <= 1'b0;
      fcmd.op       <= OP_MUL;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgCurveA: curve_a <= cfg_data;
          default:   prime_p <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_x        <= s_axis_tdata[63:0];
            in_y        <= s_axis_tdata[127:64];
            neg         <= s_axis_tdata[191];
            scalar_left <= s_axis_tdata[191] ? -s_axis_tdata[191:128]
                                             : s_axis_tdata[191:128];
            acc_inf     <= 1'b1;
            acc_x       <= '0;
            acc_y       <= '0;
            if (prime_p < W'(2) || s_axis_tuser || s_axis_tdata[191:128] == '0) begin
              state <= S_OUT;
            end else begin
              rx_in  <= CoordWidth'(curve_a);
              rstart <= 1'b1;
              state  <= S_RA;
            end
          end
        end
        S_RA: if (rdone) begin
          a_red  <= rr;
          rx_in  <= in_x;
          rstart <= 1'b1;
          state  <= S_RX;
        end
        S_RX: if (rdone) begin
          addend_x <= rr;
          rx_in    <= in_y;
          rstart   <= 1'b1;
          state    <= S_RY;
        end
        S_RY: if (rdone) begin
          addend_y   <= (neg && rr != '0) ? prime_p - rr : rr;
          addend_inf <= 1'b0;
          state      <= S_LOOP;
        end
        S_LOOP: begin
          if (scalar_left == '0) begin
            state <= S_OUT;
          end else if (scalar_left[0]) begin
            is_dbl <= 1'b0;
            state  <= S_ADD_START;
          end else begin
            is_dbl <= 1'b1;
            state  <= S_ADD_START;
          end
        end
        S_ADD_START: begin
          x1 <= is_dbl ? addend_x : acc_x;
          y1 <= is_dbl ? addend_y : acc_y;
          x2 <= addend_x;
          y2 <= addend_y;
          if (!is_dbl && acc_inf) begin
            acc_x   <= addend_x;
            acc_y   <= addend_y;
            acc_inf <= addend_inf;
            is_dbl  <= 1'b1;
          end else if (addend_inf) begin
            state <= S_WRITE;  // doubling infinity or adding it: unchanged
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (x1 == x2 && y_sum == '0) begin
            xr    <= '0;
            tmp   <= '0;
            lam   <= '1;  // marks infinity result
            state <= S_WRITE;
          end else if (x1 == x2 && y1 == y2) begin
            fa <= x1; fb <= x1; fcmd.op <= OP_MUL; fcmd.start <= 1'b1;
            state <= S_NUM_DBL1;
          end else begin
            fa <= y2; fb <= y1; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
            state <= S_NUM_ADD;
          end
        end
        S_NUM_DBL1: if (fdone) begin
          tmp <= fr;
          fa <= fr; fb <= fr; fcmd.op <= OP_ADD; fcmd.start <= 1'b1;
          state <= S_NUM_DBL2;
        end
        S_NUM_DBL2: if (fdone) begin
          fa <= fr; fb <= tmp; fcmd.op <= OP_ADD; fcmd.start <= 1'b1;
          state <= S_NUM_DBL3;
        end
        S_NUM_DBL3: if (fdone) begin
          fa <= fr; fb <= a_red; fcmd.op <= OP_ADD; fcmd.start <= 1'b1;
          state <= S_NUM_DBL4;
        end
        S_NUM_DBL4: if (fdone) begin
          num <= fr;
          fa <= y1; fb <= y1; fcmd.op <= OP_ADD; fcmd.start <= 1'b1;
          state <= S_DEN_DBL;
        end
        S_DEN_DBL, S_DEN_ADD: if (fdone) begin
          pow_base     <= fr;
          pow_result   <= W'(1);
          pow_exp_left <= prime_p - W'(2);
          state        <= S_POW;
        end
        S_NUM_ADD: if (fdone) begin
          num <= fr;
          fa <= x2; fb <= x1; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
          state <= S_DEN_ADD;
        end
        S_POW: begin
          if (pow_exp_left == '0) begin
            fa <= num; fb <= pow_result; fcmd.op <= OP_MUL; fcmd.start <= 1'b1;
            state <= S_LAM;
          end else if (pow_exp_left[0]) begin
            fa <= pow_result; fb <= pow_base; fcmd.op <= OP_MUL;
            fcmd.start <= 1'b1;
            state <= S_POW_SQ;
          end else begin
            fa <= pow_base; fb <= pow_base; fcmd.op <= OP_MUL;
            fcmd.start <= 1'b1;
            state <= S_POW_SQ;
          end
        end
        S_POW_SQ: if (fdone) begin
          if (pow_exp_left[0]) begin
            pow_result <= fr;
            pow_exp_left[0] <= 1'b0;  // square still pending
            state <= S_POW;
          end else begin
            pow_base     <= fr;
            pow_exp_left <= pow_exp_left >> 1;
            state <= S_POW;
          end
        end
        S_LAM: if (fdone) begin
          lam <= fr;
          fa <= fr; fb <= fr; fcmd.op <= OP_MUL; fcmd.start <= 1'b1;
          state <= S_XR1;
        end
        S_XR1: if (fdone) begin
          fa <= fr; fb <= x1; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
          state <= S_XR2;
        end
        S_XR2: if (fdone) begin
          fa <= fr; fb <= x2; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
          state <= S_XR3;
        end
        S_XR3: if (fdone) begin
          xr <= fr;
          fa <= x1; fb <= fr; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
          state <= S_YR1;
        end
        S_YR1: if (fdone) begin
          fa <= lam; fb <= fr; fcmd.op <= OP_MUL; fcmd.start <= 1'b1;
          state <= S_YR2;
        end
        S_YR2: if (fdone) begin
          fa <= fr; fb <= y1; fcmd.op <= OP_SUB; fcmd.start <= 1'b1;
          state <= S_YR3;
        end
        S_YR3: if (fdone) begin
          tmp <= fr;
          lam <= '0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!addend_inf) begin
            if (is_dbl) begin
              addend_x   <= xr;
              addend_y   <= tmp;
              addend_inf <= (lam == '1) && (x1 == x2) && (y_sum == '0);
            end else begin
              acc_x   <= xr;
              acc_y   <= tmp;
              acc_inf <= (lam == '1) && (x1 == x2) && (y_sum == '0);
              is_dbl  <= 1'b1;
            end
          end
          if (is_dbl || addend_inf) begin
            scalar_left <= scalar_left >> 1;
            state <= S_LOOP;
          end else begin
            state <= S_ADD_START;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_word;
            m_axis_tuser  <= acc_inf;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // in S_ADD_START an acc-infinity add copies and switches to doubling
  // without leaving the state; the next pass through does the double.

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_axis_tready)
    else $error("ready while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT)
    else $error("result valid outside output state");
endmodule
